/* sv/cmma_pkg.sv */
// Shared constants, types and the microcode ROM for the millivolt moving average.
// No dependencies; every other file imports this package.
`default_nettype none
package cmma_pkg;

  localparam int WINDOW_LEN  = 8;
  localparam int PTR_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int MV_W        = 16;
  localparam int SUM_W       = MV_W + $clog2(WINDOW_LEN);
  localparam int MV_PER_VOLT = 1000;
  localparam int SCALE_W     = 10;
  localparam int PROD_W      = MV_W + SCALE_W;
  localparam int CNT_W       = $clog2(SUM_W + 1);
  localparam bit WIN_POW2    = ((WINDOW_LEN & (WINDOW_LEN - 1)) == 0);
  localparam logic [MV_W-1:0] MV_MAX = '1;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_MUL   = 4'd1;
  localparam step_t ST_CHK   = 4'd2;
  localparam step_t ST_MVDIV = 4'd3;
  localparam step_t ST_MV    = 4'd4;
  localparam step_t ST_RING  = 4'd5;
  localparam step_t ST_MLOAD = 4'd6;
  localparam step_t ST_MDIV  = 4'd7;
  localparam step_t ST_WAIT  = 4'd8;
  localparam step_t ST_OUT   = 4'd9;

  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_NO_IN,
    J_SAT,
    J_DIV_BUSY,
    J_POW2,
    J_OUT_FULL
  } jcond_t;

  typedef struct packed {
    logic   in_rdy;
    logic   ld_mul;
    logic   ld_chk;
    logic   div_step;
    logic   ld_mv;
    logic   upd_ring;
    logic   ld_mdiv;
    logic   out_wr;
    jcond_t jcond;
    step_t  target;
  } ctrl_t;

  typedef struct packed {
    logic sat;
    logic div_busy;
    logic out_full;
  } dp_status_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    w = '0;
    unique case (step)
      ST_IDLE: begin
        w.in_rdy = 1'b1;
        w.jcond  = J_NO_IN;
        w.target = ST_IDLE;
      end
      ST_MUL:   w.ld_mul = 1'b1;
      ST_CHK: begin
        w.ld_chk = 1'b1;
        w.jcond  = J_SAT;
        w.target = ST_MV;
      end
      ST_MVDIV: begin
        w.div_step = 1'b1;
        w.jcond    = J_DIV_BUSY;
        w.target   = ST_MVDIV;
      end
      ST_MV:    w.ld_mv = 1'b1;
      ST_RING: begin
        w.upd_ring = 1'b1;
        w.jcond    = J_POW2;
        w.target   = ST_WAIT;
      end
      ST_MLOAD: w.ld_mdiv = 1'b1;
      ST_MDIV: begin
        w.div_step = 1'b1;
        w.jcond    = J_DIV_BUSY;
        w.target   = ST_MDIV;
      end
      ST_WAIT: begin
        w.jcond  = J_OUT_FULL;
        w.target = ST_WAIT;
      end
      ST_OUT: begin
        w.out_wr = 1'b1;
        w.jcond  = J_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.jcond  = J_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* sv/cmma_in_if.sv */
// Input channel: raw and reference converter counts with valid/ready.
// Depends on cmma_pkg for field widths.
`default_nettype none
interface cmma_in_if
  import cmma_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] raw_count;
  logic [MV_W-1:0] reference_count;

  modport source (output valid, output raw_count, output reference_count, input ready);
  modport sink   (input valid, input raw_count, input reference_count, output ready);
endinterface
`default_nettype wire

/* sv/cmma_out_if.sv */
// Result channel: averaged millivolts and saturation flag with valid/ready.
// Depends on cmma_pkg for field widths.
`default_nettype none
interface cmma_out_if
  import cmma_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] average_millivolts;
  logic            saturated;

  modport source (output valid, output average_millivolts, output saturated, input ready);
  modport sink   (input valid, input average_millivolts, input saturated, output ready);
endinterface
`default_nettype wire

/* sv/cmma_seq.sv */
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on cmma_pkg (ucode_rom, ctrl_t, dp_status_t).
`default_nettype none
module cmma_seq
  import cmma_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire dp_status_t status,
  output      ctrl_t      ctrl
);

  step_t step_r, step_nxt;
  logic  take;

  assign ctrl = ucode_rom(step_r);

  always_comb begin
    unique case (ctrl.jcond)
      J_NONE:     take = 1'b0;
      J_ALWAYS:   take = 1'b1;
      J_NO_IN:    take = !in_valid;
      J_SAT:      take = status.sat;
      J_DIV_BUSY: take = status.div_busy;
      J_POW2:     take = WIN_POW2;
      J_OUT_FULL: take = status.out_full;
      default:    take = 1'b1;
    endcase
    step_nxt = take ? ctrl.target : step_t'(step_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/cmma_dp.sv */
// Datapath: scale multiplier, shared restoring divider, window ring, running sum
// and output register. Driven by control words from cmma_seq; depends on cmma_pkg.
`default_nettype none
module cmma_dp
  import cmma_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ctrl_t           ctrl,
  input  wire logic            in_valid,
  input  wire logic [MV_W-1:0] in_raw,
  input  wire logic [MV_W-1:0] in_ref,
  input  wire logic            out_ready,
  output      logic            out_valid,
  output      logic [MV_W-1:0] out_avg,
  output      logic            out_sat,
  output      dp_status_t      status
);

  logic [MV_W-1:0]   raw_r, ref_r;
  logic [PROD_W-1:0] prod_r;
  logic              sat_r;
  logic              sat_now;
  logic [MV_W-1:0]   mv_r;

  // Divider
  logic [MV_W-1:0]   rem_r;
  logic [SUM_W-1:0]  dvd_r;
  logic [MV_W-1:0]   dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MV_W+1:0]   trial;
  logic              borrow;

  // Window
  logic [MV_W-1:0]   ring_r [WINDOW_LEN];
  logic [PTR_W-1:0]  ptr_r;
  logic [SUM_W-1:0]  sum_r;
  logic [MV_W-1:0]   mean;

  logic              out_valid_r;
  logic [MV_W-1:0]   out_avg_r;
  logic              out_sat_r;

  // Quotient overflows 16 bits exactly when the high product bits reach the
  // divisor; a zero reference always lands here too.
  assign sat_now = ({{(MV_W-(PROD_W-MV_W)){1'b0}}, prod_r[PROD_W-1:MV_W]} >= ref_r);

  assign trial  = {1'b0, rem_r, dvd_r[SUM_W-1]} - {2'b00, dsr_r};
  assign borrow = trial[MV_W+1];

  assign mean = WIN_POW2 ? MV_W'(sum_r >> PTR_W) : dvd_r[MV_W-1:0];

  assign status.sat      = sat_now;
  assign status.div_busy = (cnt_r != CNT_W'(1));
  assign status.out_full = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_avg   = out_avg_r;
  assign out_sat   = out_sat_r;

  // Operand capture, scaling and divider
  always_ff @(posedge clk) begin
    if (ctrl.in_rdy && in_valid) begin
      raw_r <= in_raw;
      ref_r <= in_ref;
    end
    if (ctrl.ld_mul) begin
      prod_r <= PROD_W'(raw_r) * PROD_W'(MV_PER_VOLT);
    end
    if (ctrl.ld_chk) begin
      sat_r <= sat_now;
      rem_r <= {{(MV_W-(PROD_W-MV_W)){1'b0}}, prod_r[PROD_W-1:MV_W]};
      dvd_r <= SUM_W'(prod_r[MV_W-1:0]) << (SUM_W - MV_W);
      dsr_r <= ref_r;
      cnt_r <= CNT_W'(MV_W);
    end else if (ctrl.ld_mdiv) begin
      rem_r <= '0;
      dvd_r <= sum_r;
      dsr_r <= MV_W'(WINDOW_LEN);
      cnt_r <= CNT_W'(SUM_W);
    end else if (ctrl.div_step) begin
      rem_r <= borrow ? {rem_r[MV_W-2:0], dvd_r[SUM_W-1]} : trial[MV_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], !borrow};
      cnt_r <= cnt_r - 1'b1;
    end
    if (ctrl.ld_mv) begin
      mv_r <= sat_r ? MV_MAX : dvd_r[MV_W-1:0];
    end
  end

  // Window ring, pointer and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_r[i] <= '0;
      end
      ptr_r <= '0;
      sum_r <= '0;
    end else if (ctrl.upd_ring) begin
      ring_r[ptr_r] <= mv_r;
      sum_r         <= sum_r - SUM_W'(ring_r[ptr_r]) + SUM_W'(mv_r);
      ptr_r         <= (ptr_r == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_wr) begin
      out_avg_r <= mean;
      out_sat_r <= sat_r;
    end
  end

endmodule
`default_nettype wire

/* sv/calibrated_millivolt_moving_average_top.sv */
// Calibrated millivolt moving average: ratiometric scaling, 8-entry boxcar mean.
// Input beats are handled one at a time; a saturated beat skips the divide.
// The divide uses the one-bit-per-cycle restoring divider, 16 steps per
//   millivolt quotient.
// Reset (rst_n, synchronous): window, pointer and sum cleared, sequencer idle.
// Uses cmma_pkg, cmma_in_if, cmma_out_if, cmma_seq and cmma_dp.
`default_nettype none
module calibrated_millivolt_moving_average_top
  import cmma_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  cmma_in_if.sink     in_ch,
  cmma_out_if.source  out_ch
);

  ctrl_t      ctrl;
  dp_status_t status;

  // Accept an input beat only while the program sits in its idle step.
  assign in_ch.ready = ctrl.in_rdy;

  // Step counter walks the ROM program: capture, multiply by 1000, check
  // overflow, divide unless saturated, update the ring and sum, then hand off to the
  // output register.
  cmma_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Datapath holds the operands, divider, window and the result register;
  // the result register lets a finished beat wait while the next is accepted.
  cmma_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (in_ch.valid),
    .in_raw    (in_ch.raw_count),
    .in_ref    (in_ch.reference_count),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_avg   (out_ch.average_millivolts),
    .out_sat   (out_ch.saturated),
    .status    (status)
  );

endmodule
`default_nettype wire
